// ===== rtl/aedm_pkg.sv =====
// Shared types and constants for the audio echo delay mixer.
`default_nettype none

package aedm_pkg;

   // Stream and register widths.
   localparam int WORD_W   = 16;
   localparam int DELAY_W  = 15;
   localparam int VOL_W    = 16;
   localparam int CSR_IDX_W = 8;

   // Delay line geometry.
   localparam int MAX_DELAY  = 16384;
   localparam int RING_W     = $clog2(MAX_DELAY);
   localparam int FILL_W     = RING_W + 1;

   // Header layout: word count and the positions of the two 32-bit size fields.
   localparam int HDR_CNT_W = 5;
   localparam logic [HDR_CNT_W-1:0] HDR_WORDS = 5'd22;
   localparam logic [HDR_CNT_W-1:0] SIZE_LO_A = 5'd2;
   localparam logic [HDR_CNT_W-1:0] SIZE_HI_A = 5'd3;
   localparam logic [HDR_CNT_W-1:0] SIZE_LO_B = 5'd20;
   localparam logic [HDR_CNT_W-1:0] SIZE_HI_B = 5'd21;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 8'd1;
   localparam logic [DELAY_W-1:0]   DELAY_RESET  = 15'd8000;
   localparam logic [VOL_W-1:0]     VOLUME_RESET = 16'd4;

   // Width of the divider step counter, one quotient bit per step.
   localparam int DIV_CNT_W = $clog2(WORD_W);

   // Write command into the delay line.
   typedef struct packed {
      logic              en;
      logic [RING_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } line_wr_type;

endpackage

`default_nettype wire

// ===== rtl/aedm_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module aedm_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [aedm_pkg::WORD_W-1:0] dividend,
   input  wire logic [aedm_pkg::VOL_W-1:0]  divisor,
   output logic                           done,
   output logic [aedm_pkg::WORD_W-1:0]    quotient
);
   import aedm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VOL_W-1:0]     rem_ff, rem_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [VOL_W-1:0]     dvs_ff, dvs_in;
   logic [VOL_W:0]       trial;
   logic [VOL_W:0]       diff;
   logic                 fits;

   // One trial subtraction: the next dividend bit shifts into the remainder.
   always_comb begin
      trial = {rem_ff, quo_ff[WORD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VOL_W-1:0] : trial[VOL_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the data shift registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/aedm_line.sv =====
// Echo delay line memory with a fill mark so unwritten entries read as zero.
`default_nettype none

module aedm_line (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [aedm_pkg::RING_W-1:0] rd_addr,
   output logic [aedm_pkg::WORD_W-1:0]      rd_data,
   input  wire aedm_pkg::line_wr_type       line_wr
);
   import aedm_pkg::*;

   logic [WORD_W-1:0] mem [MAX_DELAY];
   logic [WORD_W-1:0] mem_q_ff;
   logic              hit_ff, hit_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // The ring is written only from index zero upward, so the written entries
   // always form a prefix; the fill mark is one past the highest written entry.
   always_comb begin
      fill_in = fill_ff;
      if (line_wr.en && ({1'b0, line_wr.addr} >= fill_ff)) begin
         fill_in = {1'b0, line_wr.addr} + 1'b1;
      end
      hit_in = hit_ff;
      if (rd_en) begin
         hit_in = ({1'b0, rd_addr} < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         hit_ff  <= hit_in;
      end
   end

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (line_wr.en) begin
         mem[line_wr.addr] <= line_wr.data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   assign rd_data = hit_ff ? mem_q_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/audio_echo_delay_mixer_top.sv =====
// Header words pass from accept through the push state to the result register;
// samples also pass through the divide state, where the 16-step bit-serial divider
// forms the stored echo. No new word is taken until the last is in that register.
// Reset is synchronous and active high; it restores the registers to their
// defaults and empties the delay line at once through its fill mark.
// Delay line: an audio echo over a 16-bit PCM stream with a patched file header.
`default_nettype none

module audio_echo_delay_mixer_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Input words.
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [aedm_pkg::WORD_W-1:0]    req_tdata,  // [15:0] sample
   input  wire logic [0:0]                     req_tuser,  // [0] mode (1 = flush)
   // Result words.
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [aedm_pkg::WORD_W-1:0]         rsp_tdata,  // [15:0] out_word
   // Register writes.
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [aedm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [aedm_pkg::VOL_W-1:0]     csr_data
);
   import aedm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [VOL_W-1:0]     vol_ff, vol_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic                 carry_ff, carry_in;
   logic [RING_W-1:0]    ring_ff, ring_in;
   logic [RING_W-1:0]    idx_ff, idx_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 neg_ff, neg_in;
   logic [WORD_W-1:0]    res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [DELAY_W-1:0]   d_eff;
   logic [WORD_W:0]      size_add;
   logic [WORD_W-1:0]    word;
   logic [WORD_W:0]      hdr_sum;
   logic [FILL_W-1:0]    idx_next;
   logic                 accept;
   logic                 div_start;
   logic [WORD_W-1:0]    div_dividend;
   logic [VOL_W-1:0]     div_divisor;
   logic                 div_done;
   logic [WORD_W-1:0]    div_quotient;
   logic                 rd_en;
   logic [RING_W-1:0]    rd_addr;
   logic [WORD_W-1:0]    echo;
   line_wr_type          line_wr;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      delay_in = delay_ff;
      vol_in   = vol_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DELAY:  delay_in = csr_data[DELAY_W-1:0];
            CSR_VOLUME: vol_in   = csr_data;
            default: ;
         endcase
      end
   end

   // Effective delay, clamped to the line, and the amount added to size fields.
   always_comb begin
      if (delay_ff == '0) begin
         d_eff = DELAY_W'(1);
      end else if (delay_ff > DELAY_W'(MAX_DELAY)) begin
         d_eff = DELAY_W'(MAX_DELAY);
      end else begin
         d_eff = delay_ff;
      end
      size_add = {1'b0, d_eff, 1'b0};
   end

   assign word       = req_tuser[0] ? '0 : req_tdata;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   aedm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   aedm_line u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (echo),
      .line_wr (line_wr)
   );

   // Sequencer: header words go straight to the push state, samples wait for the divider.
   always_comb begin
      state_in     = state_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      carry_in     = carry_ff;
      ring_in      = ring_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = word[WORD_W-1] ? (~word + 1'b1) : word;
      div_divisor  = (vol_ff == '0) ? VOL_W'(1) : vol_ff;
      rd_en        = 1'b0;
      rd_addr      = ({1'b0, ring_ff} >= d_eff) ? '0 : ring_ff;
      line_wr      = '{en: 1'b0, addr: idx_ff, data: '0};
      hdr_sum      = '0;
      idx_next     = {1'b0, idx_ff} + 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (hdr_cnt_ff < HDR_WORDS) begin
                  // Header word; the size fields get twice the effective delay added.
                  res_in = word;
                  if (hdr_cnt_ff == SIZE_LO_A || hdr_cnt_ff == SIZE_LO_B) begin
                     hdr_sum  = {1'b0, word} + {1'b0, size_add[WORD_W-1:0]};
                     res_in   = hdr_sum[WORD_W-1:0];
                     carry_in = hdr_sum[WORD_W];
                  end else if (hdr_cnt_ff == SIZE_HI_A || hdr_cnt_ff == SIZE_HI_B) begin
                     hdr_sum  = {1'b0, word} + {{WORD_W{1'b0}}, size_add[WORD_W]}
                              + {{WORD_W{1'b0}}, carry_ff};
                     res_in   = hdr_sum[WORD_W-1:0];
                     carry_in = 1'b0;
                  end
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  state_in   = ST_PUSH;
               end else begin
                  // Sample: read the echo and start the divider.
                  rd_en     = 1'b1;
                  idx_in    = rd_addr;
                  word_in   = word;
                  neg_in    = word[WORD_W-1];
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in       = word_ff + echo;
               line_wr.en   = 1'b1;
               line_wr.data = neg_ff ? (~div_quotient + 1'b1) : div_quotient;
               ring_in      = (idx_next >= d_eff) ? '0 : idx_next[RING_W-1:0];
               state_in     = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= DELAY_RESET;
         vol_ff       <= VOLUME_RESET;
         hdr_cnt_ff   <= '0;
         carry_ff     <= 1'b0;
         ring_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         vol_ff       <= vol_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         carry_ff     <= carry_in;
         ring_ff      <= ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
